FILE: hw/rtl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Types, constants and the UTF-8 encoder shared by the transcoder modules.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam int unsigned QDEPTH = 2;  // power of two
	localparam int unsigned QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	localparam logic [20:0] CP_ONE_LIMIT   = 21'h00080;
	localparam logic [20:0] CP_TWO_LIMIT   = 21'h00800;
	localparam logic [20:0] CP_THREE_LIMIT = 21'h10000;

	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_LONE_LOW    = 2'd1,
		STATUS_BROKEN_PAIR = 2'd2,
		STATUS_TRUNCATED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} enc_t;

	// One request of the back end: the bytes of one unit, or one error.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		status_t         status;
		logic            str_last;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < CP_ONE_LIMIT) begin
			e.bytes[0] = cp[7:0];
			e.last_idx = 2'd0;
		end else if (cp < CP_TWO_LIMIT) begin
			e.bytes[0] = {LEAD2_TAG, cp[10:6]};
			e.bytes[1] = {CONT_TAG, cp[5:0]};
			e.last_idx = 2'd1;
		end else if (cp < CP_THREE_LIMIT) begin
			e.bytes[0] = {LEAD3_TAG, cp[15:12]};
			e.bytes[1] = {CONT_TAG, cp[11:6]};
			e.bytes[2] = {CONT_TAG, cp[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.bytes[0] = {LEAD4_TAG, cp[20:18]};
			e.bytes[1] = {CONT_TAG, cp[17:12]};
			e.bytes[2] = {CONT_TAG, cp[11:6]};
			e.bytes[3] = {CONT_TAG, cp[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

endpackage

FILE: hw/rtl/u2u8_if.sv
// ----------------------------------------------------------------------------
// u2u8 stream interfaces
// Valid/ready channels for UTF-16 code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u2u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        string_last;

	modport source (output valid, output code_unit, output string_last, input ready);
	modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface u2u8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic [1:0] status;
	logic       string_end;

	modport source (output valid, output out_byte, output run_last, output status,
		output string_end, input ready);
	modport sink   (input valid, input out_byte, input run_last, input status,
		input string_end, output ready);
endinterface

FILE: hw/rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and errors.
// ----------------------------------------------------------------------------
//  port   | dir | payload                                  | handshake
//  units  | in  | code_unit[15:0], string_last             | valid/ready
//  utf8   | out | out_byte[7:0], run_last, status, string_end | valid/ready
//
// The back end sends one byte per cycle while the output is ready; a unit yields
// one output byte per UTF-8 byte or error, none for a held high surrogate, and
// the output byte port sets the sustained rate. A taken unit's request is
// written into the queue, then its first byte is loaded into the output register.
// A two-entry request queue lets units enter while bytes of earlier units wait.
// Reset clears the held surrogate, queue and output valid.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	u2u8_unit_if.sink   units,
	u2u8_byte_if.source utf8
);

	logic               push;
	logic               pop;
	u2u8_pkg::rec_t     push_rec;
	u2u8_pkg::rec_t     head;
	u2u8_pkg::q_flags_t q_flags;

	u2u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.units    (units),
		.q_flags  (q_flags),
		.push     (push),
		.push_rec (push_rec)
	);

	u2u8_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.flags    (q_flags)
	);

	u2u8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_flags (q_flags),
		.pop     (pop),
		.utf8    (utf8)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_flags.full)
		else $error("request pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_flags.empty)
		else $error("request popped from empty queue");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(utf8.valid && utf8.status != u2u8_pkg::STATUS_OK)
		|-> (utf8.run_last && utf8.out_byte == 8'd0))
		else $error("error result not a single zero byte");

	a_end_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		(utf8.valid && utf8.string_end) |-> utf8.run_last)
		else $error("string end off the last byte of a run");

endmodule

FILE: hw/rtl/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks a pending high surrogate and builds one request
// per unit that yields output: the encoded bytes or a single error.
// ----------------------------------------------------------------------------
module u2u8_front (
	input  logic                clk,
	input  logic                arst_n,
	u2u8_unit_if.sink           units,
	input  u2u8_pkg::q_flags_t  q_flags,
	output logic                push,
	output u2u8_pkg::rec_t      push_rec
);

	logic       pending_q;
	logic [9:0] held_q;
	logic       take;
	logic       is_high;
	logic       is_low;
	logic       hold_high;
	logic [20:0] cp;
	u2u8_pkg::enc_t enc;

	assign units.ready = !q_flags.full;
	assign take        = units.valid && units.ready;

	always_comb begin
		is_high   = units.code_unit inside {[u2u8_pkg::HIGH_FIRST : u2u8_pkg::HIGH_LAST]};
		is_low    = units.code_unit inside {[u2u8_pkg::LOW_FIRST : u2u8_pkg::LOW_LAST]};
		hold_high = !pending_q && is_high && !units.string_last;

		if (pending_q)
			cp = u2u8_pkg::CP_THREE_LIMIT + 21'({held_q, units.code_unit[9:0]});
		else
			cp = 21'(units.code_unit);
		enc = u2u8_pkg::utf8_encode(cp);

		push_rec          = '0;
		push_rec.str_last = units.string_last;
		if (pending_q && !is_low) begin
			push_rec.status = u2u8_pkg::STATUS_BROKEN_PAIR;
		end else if (!pending_q && is_high) begin
			push_rec.status = u2u8_pkg::STATUS_TRUNCATED;
		end else if (!pending_q && is_low) begin
			push_rec.status = u2u8_pkg::STATUS_LONE_LOW;
		end else begin
			push_rec.status   = u2u8_pkg::STATUS_OK;
			push_rec.bytes    = enc.bytes;
			push_rec.last_idx = enc.last_idx;
		end

		push = take && !hold_high;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= '0;
		end else if (take) begin
			pending_q <= hold_high;
			held_q    <= hold_high ? units.code_unit[9:0] : 10'd0;
		end
	end

endmodule

FILE: hw/rtl/u2u8_fifo.sv
// ----------------------------------------------------------------------------
// u2u8_fifo
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
module u2u8_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u2u8_pkg::rec_t      push_rec,
	input  logic                pop,
	output u2u8_pkg::rec_t      head,
	output u2u8_pkg::q_flags_t  flags
);

	u2u8_pkg::rec_t mem_q [u2u8_pkg::QDEPTH];
	logic [u2u8_pkg::QIDX_W-1:0] wr_ptr_q;
	logic [u2u8_pkg::QIDX_W-1:0] rd_ptr_q;
	logic [u2u8_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign flags.full  = (count_q == u2u8_pkg::QCNT_W'(u2u8_pkg::QDEPTH));
	assign flags.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + u2u8_pkg::QIDX_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + u2u8_pkg::QIDX_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + u2u8_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - u2u8_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Walks the head request one byte per cycle, while the output is ready, into the output register.
// ----------------------------------------------------------------------------
module u2u8_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u2u8_pkg::rec_t      head,
	input  u2u8_pkg::q_flags_t  q_flags,
	output logic                pop,
	u2u8_byte_if.source         utf8
);

	logic       valid_q;
	logic [1:0] idx_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic [1:0] status_q;
	logic       string_end_q;
	logic       load;
	logic       fin;

	assign load = (!valid_q || utf8.ready) && !q_flags.empty;
	assign fin  = (idx_q == head.last_idx);
	assign pop  = load && fin;

	assign utf8.valid      = valid_q;
	assign utf8.out_byte   = byte_q;
	assign utf8.run_last   = run_last_q;
	assign utf8.status     = status_q;
	assign utf8.string_end = string_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (utf8.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= head.bytes[idx_q];
			run_last_q   <= fin;
			status_q     <= head.status;
			string_end_q <= fin && head.str_last;
		end
	end

endmodule
